// ----- src/pbce_pkg.sv -----
// shared types and constants for the piecewise bezier curve evaluator
// no dependencies; used by the top level and its checker

package pbce_pkg;

  // fixed field widths
  localparam int VALUE_BITS   = 16;
  localparam int COUNT_BITS   = 5;
  localparam int INDEX_BITS   = 4;
  localparam int MAX_KNOTS_DEF = 16;

  // t limits in q4.16
  localparam int T_ONE = 65536;
  localparam int T_MAX = 524287;
  localparam int T_MIN_MAG = 524288;

  // request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_EVAL  = 1'b1;

  // one table entry
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] x;
    logic signed [VALUE_BITS-1:0] y;
    logic signed [VALUE_BITS-1:0] h;
  } knot_t;

endpackage

// ----- src/piecewise_bezier_curve_eval.sv -----
// piecewise cubic bezier curve evaluator, top level
// depends on pbce_pkg
//
// usage: the input channel (in_valid/in_ready) carries one word per request.
// req_type write stores knot_x, knot_y, handle_y at knot_index; req_type eval
// evaluates the curve at query_x. every request returns exactly one word on
// the output channel (out_valid/out_ready); writes return zeros.
// knot_count is to be set by the user through cfg_we/cfg_data only while the
// block is idle; the block does not enforce this. a write goes from idle
// straight to the done state. an evaluation scans the knot table through the
// single memory read port, one entry a cycle, then runs a 32-step restoring
// divider for t and 16 steps of one shared multiplier for the bernstein
// weights and the weighted sum; a zero-width segment skips both.
// one request is in flight at a time; in_ready is high only when idle.
// the result sits in an output register, so a stalled receiver only holds the
// next result back; the block holds it until out_ready.
// reset clears control state and sets knot_count to 2; table contents are
// undefined until written.

module piecewise_bezier_curve_eval import pbce_pkg::*; #(
  parameter int MAX_KNOTS = MAX_KNOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [COUNT_BITS-1:0]        cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         req_type,
  input  logic [INDEX_BITS-1:0]        knot_index,
  input  logic signed [VALUE_BITS-1:0] knot_x,
  input  logic signed [VALUE_BITS-1:0] knot_y,
  input  logic signed [VALUE_BITS-1:0] handle_y,
  input  logic signed [VALUE_BITS-1:0] query_x,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [VALUE_BITS-1:0] curve_value,
  output logic                         saturated,
  output logic                         zero_width_error
);

  localparam int IW = (MAX_KNOTS > 2) ? $clog2(MAX_KNOTS) : 1;
  localparam int CW = $clog2(MAX_KNOTS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_PREP  = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]            state;
  logic [COUNT_BITS-1:0] knot_count;

  // knot table
  knot_t                 mem [MAX_KNOTS];
  knot_t                 rd_data;
  logic                  mem_we;
  logic [IW-1:0]         scan_addr;
  logic                  issue_on;
  logic                  data_ok;
  logic [IW-1:0]         data_idx;

  // segment search
  logic signed [VALUE_BITS-1:0] q_r;
  knot_t                 prev_k, e0_k, e1_k, lo_k, hi_k;
  logic [CW-1:0]         n_eff;
  logic [IW-1:0]         n_last;

  // divider
  logic [31:0]           dvd;
  logic [15:0]           dvs;
  logic [15:0]           rem;
  logic [4:0]            div_cnt;
  logic                  neg;
  logic [16:0]           rem_s;

  // bernstein datapath
  logic signed [20:0]    t_r, u_r;
  logic signed [22:0]    t3, u3;
  logic signed [41:0]    a_r, b_r, c_r;
  logic signed [55:0]    hi_p;
  logic signed [31:0]    w0, w1, w2, w3;
  logic signed [49:0]    acc;
  logic signed [17:0]    m_r;
  logic [3:0]            step;
  logic signed [32:0]    mul_a;
  logic signed [22:0]    mul_b;
  logic signed [55:0]    prod;
  logic signed [63:0]    wsum;

  // result holding
  logic signed [VALUE_BITS-1:0] res_val;
  logic                  res_sat, res_zerr;

  // setup arithmetic
  logic signed [16:0]    dx, diff;
  logic [16:0]           dx_abs, diff_abs;
  logic [31:0]           qmag;
  logic                  t_big;
  logic signed [20:0]    t_new;
  logic signed [21:0]    u_wide;
  logic signed [33:0]    r_full;

  assign in_ready = (state == S_IDLE);
  assign mem_we   = in_valid && in_ready && (req_type == REQ_WRITE)
                    && (32'(knot_index) < MAX_KNOTS);

  // clamp knot_count to at least 2 and at most the table size
  always_comb begin
    if (knot_count < COUNT_BITS'(2)) begin
      n_eff = CW'(2);
    end else if (32'(knot_count) > MAX_KNOTS) begin
      n_eff = CW'(MAX_KNOTS);
    end else begin
      n_eff = CW'(knot_count);
    end
    n_last = IW'(n_eff - CW'(1));
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[IW'(knot_index)] <= '{x: knot_x, y: knot_y, h: handle_y};
    end
    rd_data <= mem[scan_addr];
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      knot_count <= COUNT_BITS'(2);
    end else if (cfg_we) begin
      knot_count <= cfg_data;
    end
  end

  // segment width and offset, and the divider's shifted remainder
  always_comb begin
    dx       = {hi_k.x[15], hi_k.x} - {lo_k.x[15], lo_k.x};
    diff     = {q_r[15], q_r} - {lo_k.x[15], lo_k.x};
    dx_abs   = dx[16] ? -dx : dx;
    diff_abs = diff[16] ? -diff : diff;
    rem_s    = {rem, dvd[31]};
  end

  // clamp quotient to q4.16 t and form u = 1 - t
  always_comb begin
    qmag  = dvd;
    t_big = neg ? (qmag > 32'(T_MIN_MAG)) : (qmag > 32'(T_MAX));
    if (t_big) begin
      t_new = neg ? -21'sd524288 : 21'sd524287;
    end else begin
      t_new = neg ? -$signed(qmag[20:0]) : $signed(qmag[20:0]);
    end
    u_wide = 22'sd65536 - {t_new[20], t_new};
  end

  assign t3 = {{2{t_r[20]}}, t_r} + {t_r[20], t_r, 1'b0};
  assign u3 = {{2{u_r[20]}}, u_r} + {u_r[20], u_r, 1'b0};

  // multiplier operand schedule
  always_comb begin
    case (step)
      4'd0:  begin mul_a = 33'(u_r); mul_b = 23'(u_r); end
      4'd1:  begin mul_a = 33'(u_r); mul_b = 23'(t_r); end
      4'd2:  begin mul_a = 33'(t_r); mul_b = 23'(t_r); end
      4'd3:  begin mul_a = 33'(a_r[41:21]); mul_b = 23'(u_r); end
      4'd4:  begin mul_a = {12'd0, a_r[20:0]}; mul_b = 23'(u_r); end
      4'd5:  begin mul_a = 33'($signed(b_r[41:21])); mul_b = u3; end
      4'd6:  begin mul_a = {12'd0, b_r[20:0]}; mul_b = u3; end
      4'd7:  begin mul_a = 33'($signed(b_r[41:21])); mul_b = t3; end
      4'd8:  begin mul_a = {12'd0, b_r[20:0]}; mul_b = t3; end
      4'd9:  begin mul_a = 33'(c_r[41:21]); mul_b = 23'(t_r); end
      4'd10: begin mul_a = {12'd0, c_r[20:0]}; mul_b = 23'(t_r); end
      4'd11: begin mul_a = 33'(w0); mul_b = 23'(lo_k.y); end
      4'd12: begin mul_a = 33'(w1); mul_b = 23'(lo_k.h); end
      4'd13: begin mul_a = 33'(w2); mul_b = 23'(m_r); end
      4'd14: begin mul_a = 33'(w3); mul_b = 23'(hi_k.y); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // joins high and low partial products of a weight
  assign wsum   = {hi_p[42:0], 21'd0} + {{8{prod[55]}}, prod};
  assign r_full = acc[49:16];

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      issue_on  <= 1'b0;
      data_ok   <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            q_r       <= query_x;
            scan_addr <= '0;
            issue_on  <= 1'b1;
            data_ok   <= 1'b0;
            res_val   <= '0;
            res_sat   <= 1'b0;
            res_zerr  <= 1'b0;
            state     <= (req_type == REQ_EVAL) ? S_SCAN : S_DONE;
          end
        end
        S_SCAN: begin
          // issue reads
          data_ok  <= issue_on;
          data_idx <= scan_addr;
          if (issue_on) begin
            if (scan_addr == n_last) begin
              issue_on <= 1'b0;
            end else begin
              scan_addr <= scan_addr + IW'(1);
            end
          end
          // check returned entry against the previous one
          if (data_ok) begin
            prev_k <= rd_data;
            if (data_idx == '0) begin
              e0_k <= rd_data;
            end
            if (data_idx == IW'(1)) begin
              e1_k <= rd_data;
            end
            if (data_idx != '0) begin
              if (prev_k.x <= q_r && q_r < rd_data.x) begin
                lo_k  <= prev_k;
                hi_k  <= rd_data;
                state <= S_SETUP;
              end else if (data_idx == n_last) begin
                if (q_r >= rd_data.x) begin
                  lo_k <= prev_k;
                  hi_k <= rd_data;
                end else begin
                  lo_k <= e0_k;
                  hi_k <= (data_idx == IW'(1)) ? rd_data : e1_k;
                end
                state <= S_SETUP;
              end
            end
          end
        end
        S_SETUP: begin
          issue_on <= 1'b0;
          data_ok  <= 1'b0;
          m_r      <= {hi_k.y[15], hi_k.y, 1'b0} - {{2{hi_k.h[15]}}, hi_k.h};
          if (dx == '0) begin
            res_val  <= lo_k.y;
            res_zerr <= 1'b1;
            state    <= S_DONE;
          end else begin
            dvs     <= dx_abs[15:0];
            dvd     <= {diff_abs[15:0], 16'd0};
            rem     <= '0;
            neg     <= diff[16] ^ dx[16];
            div_cnt <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          // one quotient bit a cycle
          if (rem_s >= {1'b0, dvs}) begin
            rem <= 16'(rem_s - {1'b0, dvs});
            dvd <= {dvd[30:0], 1'b1};
          end else begin
            rem <= rem_s[15:0];
            dvd <= {dvd[30:0], 1'b0};
          end
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd31) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          t_r     <= t_new;
          u_r     <= u_wide[20:0];
          res_sat <= t_big;
          step    <= '0;
          state   <= S_MUL;
        end
        S_MUL: begin
          step <= step + 4'd1;
          case (step)
            4'd1:  a_r  <= prod[41:0];
            4'd2:  b_r  <= prod[41:0];
            4'd3:  c_r  <= prod[41:0];
            4'd4:  hi_p <= prod;
            4'd5:  w0   <= wsum[63:32];
            4'd6:  hi_p <= prod;
            4'd7:  w1   <= wsum[63:32];
            4'd8:  hi_p <= prod;
            4'd9:  w2   <= wsum[63:32];
            4'd10: hi_p <= prod;
            4'd11: w3   <= wsum[63:32];
            4'd12: acc  <= prod[49:0];
            4'd13: acc  <= acc + prod[49:0];
            4'd14: acc  <= acc + prod[49:0];
            4'd15: begin
              acc   <= acc + prod[49:0];
              state <= S_FIN;
            end
            default: ;
          endcase
        end
        S_FIN: begin
          // floor by 16 bits and clamp
          if (r_full > 34'sd32767) begin
            res_val <= 16'sd32767;
            res_sat <= 1'b1;
          end else if (r_full < -34'sd32768) begin
            res_val <= -16'sd32768;
            res_sat <= 1'b1;
          end else begin
            res_val <= r_full[15:0];
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            curve_value      <= res_val;
            saturated        <= res_sat;
            zero_width_error <= res_zerr;
            out_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/pbce_checker.sv -----
// port-level checks for the piecewise bezier curve evaluator
// depends on pbce_pkg; bound to piecewise_bezier_curve_eval

module pbce_checker import pbce_pkg::*; (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [VALUE_BITS-1:0] curve_value,
  input logic                         saturated,
  input logic                         zero_width_error
);

  // a stalled result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(curve_value))
    else $error("output word dropped or changed while stalled");

  // one request at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a request is in flight");

  // no result can appear in the cycle after an accept
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result word appeared too early");

  // zero-width segments never report clamping
  a_zerr_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_width_error |-> !saturated)
    else $error("zero width word marked saturated");

endmodule

bind piecewise_bezier_curve_eval pbce_checker u_pbce_checker (.*);
